@@ hdl/nolp_pkg.sv @@
package nolp_pkg;

  localparam int CHAR_W      = 16;
  localparam int START_W     = 12;
  localparam int LEN_W       = 13;
  localparam int ERR_W       = 3;
  localparam int CFG_IDX_W   = 2;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  localparam logic [CHAR_W-1:0] CHAR_SPACE = 16'd32;
  localparam logic [CHAR_W-1:0] CHAR_TAB   = 16'd9;

  localparam logic [CHAR_W-1:0] OPEN_RESET  = 16'd40;
  localparam logic [CHAR_W-1:0] CLOSE_RESET = 16'd41;
  localparam logic [CHAR_W-1:0] SEP_RESET   = 16'd32;

  localparam logic [CFG_IDX_W-1:0] CFG_OPEN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLOSE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SEP   = 2'd2;

  localparam logic [ERR_W-1:0] ERR_NONE        = 3'd0;
  localparam logic [ERR_W-1:0] ERR_STRAY_CLOSE = 3'd1;
  localparam logic [ERR_W-1:0] ERR_BAD_SYMBOL  = 3'd2;
  localparam logic [ERR_W-1:0] ERR_UNTERM      = 3'd3;
  localparam logic [ERR_W-1:0] ERR_NO_SEP      = 3'd4;
  localparam logic [ERR_W-1:0] ERR_TOO_DEEP    = 3'd5;
  localparam logic [ERR_W-1:0] ERR_TOO_LONG    = 3'd6;

  // Character class handed from the front end to the parser.
  typedef struct packed {
    logic blank;
    logic is_open;
    logic is_close;
    logic is_sep;
    logic fin;
  } tok_t;

  typedef struct packed {
    logic               record_valid;
    logic [START_W-1:0] name_start;
    logic [LEN_W-1:0]   name_length;
    logic               has_argument;
    logic [START_W-1:0] arg_start;
    logic [LEN_W-1:0]   arg_length;
    logic [ERR_W-1:0]   error_code;
    logic               end_of_list;
  } res_t;

endpackage

@@ hdl/nested_option_list_parser.sv @@
// A result, if any, reaches the output register after its character passes the queue.
// Throughput: one character per cycle while results are taken; the parser retires one
//   queued character per cycle whenever the output register is empty or being taken.
// Reset: synchronous, active low; clears the parse state, the character queue, the output
//   register valid and restores the delimiters to open 40, close 41, separator 32.
module nested_option_list_parser #(
  parameter int MAX_CHARS = 4096,
  parameter int MAX_DEPTH = 255
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [nolp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [nolp_pkg::CHAR_W-1:0]        cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [nolp_pkg::CHAR_W-1:0]        in_character,
  input  logic                               in_final_char,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_record_valid,
  output logic [nolp_pkg::START_W-1:0]       out_name_start,
  output logic [nolp_pkg::LEN_W-1:0]         out_name_length,
  output logic                               out_has_argument,
  output logic [nolp_pkg::START_W-1:0]       out_arg_start,
  output logic [nolp_pkg::LEN_W-1:0]         out_arg_length,
  output logic [nolp_pkg::ERR_W-1:0]         out_error_code,
  output logic                               out_end_of_list
);

  // Front end: hold the delimiter registers and reduce each character to its class.
  // Queue: four entries of classes so either side can stall without stopping the other.
  // Back end: option grammar, one class per cycle unless the result stalls, into a register.

  nolp_pkg::tok_t front_tok;
  nolp_pkg::tok_t head_tok;
  nolp_pkg::res_t res;
  logic           q_full, q_not_empty, q_pop, push;

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  nolp_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_character (in_character),
    .in_final_char(in_final_char),
    .tok          (front_tok)
  );

  nolp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (front_tok),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (head_tok)
  );

  nolp_back #(
    .MAX_CHARS (MAX_CHARS),
    .MAX_DEPTH (MAX_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .tok_valid (q_not_empty),
    .tok       (head_tok),
    .tok_pop   (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (res)
  );

  // Unpack the result transaction onto its field ports.
  assign out_record_valid = res.record_valid;
  assign out_name_start   = res.name_start;
  assign out_name_length  = res.name_length;
  assign out_has_argument = res.has_argument;
  assign out_arg_start    = res.arg_start;
  assign out_arg_length   = res.arg_length;
  assign out_error_code   = res.error_code;
  assign out_end_of_list  = res.end_of_list;

endmodule

@@ hdl/nolp_front.sv @@
module nolp_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [nolp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nolp_pkg::CHAR_W-1:0]     cfg_wdata,
  input  logic [nolp_pkg::CHAR_W-1:0]     in_character,
  input  logic                            in_final_char,
  output nolp_pkg::tok_t                  tok
);

  logic [nolp_pkg::CHAR_W-1:0] open_char_r, close_char_r, sep_char_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_char_r  <= nolp_pkg::OPEN_RESET;
      close_char_r <= nolp_pkg::CLOSE_RESET;
      sep_char_r   <= nolp_pkg::SEP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        nolp_pkg::CFG_OPEN:  open_char_r  <= cfg_wdata;
        nolp_pkg::CFG_CLOSE: close_char_r <= cfg_wdata;
        nolp_pkg::CFG_SEP:   sep_char_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Classify against the delimiters; the parser never needs the character itself.
  always_comb begin
    tok.blank    = (in_character == nolp_pkg::CHAR_SPACE) ||
                   (in_character == nolp_pkg::CHAR_TAB);
    tok.is_open  = (in_character == open_char_r);
    tok.is_close = (in_character == close_char_r);
    tok.is_sep   = (in_character == sep_char_r);
    tok.fin      = in_final_char;
  end

endmodule

@@ hdl/nolp_queue.sv @@
module nolp_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  nolp_pkg::tok_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output nolp_pkg::tok_t head
);

  nolp_pkg::tok_t                mem_r [nolp_pkg::QUEUE_DEPTH];
  logic [nolp_pkg::QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [nolp_pkg::QCNT_W-1:0]   count_r;

  assign full      = (count_r == nolp_pkg::QCNT_W'(nolp_pkg::QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= nolp_pkg::QCNT_W'(nolp_pkg::QUEUE_DEPTH))
    else $error("queue count above depth");

  a_push_only_grows: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> count_r == $past(count_r) + 1'b1)
    else $error("queue count did not advance on push");
`endif

endmodule

@@ hdl/nolp_back.sv @@
module nolp_back #(
  parameter int MAX_CHARS = 4096,
  parameter int MAX_DEPTH = 255
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           tok_valid,
  input  nolp_pkg::tok_t tok,
  output logic           tok_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output nolp_pkg::res_t out_data
);

  localparam int POS_W   = $clog2(MAX_CHARS + 1);
  localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);
  localparam logic [POS_W-1:0]   POS_LIMIT = POS_W'(MAX_CHARS);
  localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(MAX_DEPTH);
  localparam int LW = nolp_pkg::LEN_W;
  localparam int SW = nolp_pkg::START_W;

  typedef enum logic [5:0] {
    PH_SKIP       = 6'b000001,
    PH_NAME       = 6'b000010,
    PH_AFTER_NAME = 6'b000100,
    PH_ARG        = 6'b001000,
    PH_AFTER_ARG  = 6'b010000,
    PH_DRAIN      = 6'b100000
  } phase_t;

  phase_t              phase_r, phase_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [LW-1:0]       nb_r, nb_nxt;
  logic [LW-1:0]       nf_r, nf_nxt;
  logic [LW-1:0]       af_r, af_nxt;
  logic [LW-1:0]       al_r, al_nxt;
  logic                seen_r, seen_nxt;
  logic [DEPTH_W-1:0]  depth_r, depth_nxt;
  logic                out_valid_r;
  nolp_pkg::res_t      out_data_r;

  logic [POS_W+LW-1:0] pos_ext;
  logic [LW-1:0]       pos13;
  logic                delim, go_name, go_after, arg_done, restart, emit;
  nolp_pkg::res_t      res;

  assign pos_ext   = {{LW{1'b0}}, pos_r};
  assign pos13     = pos_ext[LW-1:0];
  assign delim     = tok.blank | tok.is_open | tok.is_close | tok.is_sep;
  assign tok_pop   = tok_valid && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    nb_nxt    = nb_r;
    nf_nxt    = nf_r;
    af_nxt    = af_r;
    al_nxt    = al_r;
    seen_nxt  = seen_r;
    depth_nxt = depth_r;
    go_name   = 1'b0;
    go_after  = 1'b0;
    arg_done  = 1'b0;
    restart   = 1'b0;
    emit      = 1'b0;
    res       = '0;

    if (tok_pop) begin
      if (phase_r == PH_DRAIN) begin
        restart = tok.fin;
      end else if (pos_r >= POS_LIMIT) begin
        emit = 1'b1;
        res.error_code  = nolp_pkg::ERR_TOO_LONG;
        res.end_of_list = 1'b1;
        phase_nxt = PH_DRAIN;
        restart   = tok.fin;
      end else begin
        pos_nxt = pos_r + 1'b1;
        unique case (phase_r) inside
          PH_SKIP, PH_NAME, PH_AFTER_NAME: begin
            if (phase_r == PH_SKIP) begin
              if (tok.blank || tok.is_sep) begin
                emit            = tok.fin;
                res.end_of_list = 1'b1;
                restart         = tok.fin;
              end else begin
                nb_nxt    = pos13;
                phase_nxt = PH_NAME;
                go_name   = 1'b1;
              end
            end
            if (phase_r == PH_NAME || go_name) begin
              if (!delim) begin
                // Name runs to the last character of the string.
                emit             = tok.fin;
                res.record_valid = 1'b1;
                res.name_start   = nb_nxt[SW-1:0];
                res.name_length  = pos13 + 1'b1 - nb_nxt;
                res.end_of_list  = 1'b1;
                restart          = tok.fin;
              end else begin
                nf_nxt    = pos13;
                phase_nxt = PH_AFTER_NAME;
                go_after  = 1'b1;
              end
            end
            if (phase_r == PH_AFTER_NAME || go_after) begin
              res.name_start  = nb_nxt[SW-1:0];
              res.name_length = nf_nxt - nb_nxt;
              if (tok.blank) begin
                // Blanks after a bare name end the option at end of string.
                emit             = tok.fin;
                res.record_valid = 1'b1;
                res.end_of_list  = 1'b1;
                restart          = tok.fin;
              end else if (tok.is_close) begin
                emit = 1'b1;
                res  = '0;
                res.error_code  = nolp_pkg::ERR_STRAY_CLOSE;
                res.end_of_list = 1'b1;
                phase_nxt = PH_DRAIN;
                restart   = tok.fin;
              end else if (tok.is_sep) begin
                emit             = 1'b1;
                res.record_valid = 1'b1;
                res.end_of_list  = tok.fin;
                phase_nxt        = PH_SKIP;
                restart          = tok.fin;
              end else if (tok.is_open) begin
                depth_nxt = DEPTH_W'(1);
                seen_nxt  = 1'b0;
                af_nxt    = pos13 + 1'b1;
                al_nxt    = pos13 + 1'b1;
                phase_nxt = PH_ARG;
                if (tok.fin) begin
                  emit = 1'b1;
                  res  = '0;
                  res.error_code  = nolp_pkg::ERR_UNTERM;
                  res.end_of_list = 1'b1;
                  restart = 1'b1;
                end
              end else begin
                emit = 1'b1;
                res  = '0;
                res.error_code  = nolp_pkg::ERR_BAD_SYMBOL;
                res.end_of_list = 1'b1;
                phase_nxt = PH_DRAIN;
                restart   = tok.fin;
              end
            end
          end
          PH_ARG: begin
            if (tok.is_open && !tok.is_close) begin
              if (depth_r >= DEPTH_MAX) begin
                emit            = 1'b1;
                res.error_code  = nolp_pkg::ERR_TOO_DEEP;
                res.end_of_list = 1'b1;
                phase_nxt       = PH_DRAIN;
                restart         = tok.fin;
                arg_done        = 1'b1;
              end else begin
                depth_nxt = depth_r + 1'b1;
              end
            end else if (tok.is_close && !tok.is_open) begin
              depth_nxt = depth_r - 1'b1;
              if (depth_r == DEPTH_W'(1)) begin
                emit             = 1'b1;
                res.record_valid = 1'b1;
                res.name_start   = nb_r[SW-1:0];
                res.name_length  = nf_r - nb_r;
                res.has_argument = 1'b1;
                res.arg_start    = af_r[SW-1:0];
                res.arg_length   = seen_r ? (al_r - af_r + 1'b1) : '0;
                res.end_of_list  = tok.fin;
                phase_nxt        = PH_AFTER_ARG;
                restart          = tok.fin;
                arg_done         = 1'b1;
              end
            end
            if (!arg_done) begin
              // Track the trimmed extent of the argument.
              if (!tok.blank) begin
                if (!seen_r) begin
                  af_nxt   = pos13;
                  seen_nxt = 1'b1;
                end
                al_nxt = pos13;
              end
              if (tok.fin) begin
                emit            = 1'b1;
                res.error_code  = nolp_pkg::ERR_UNTERM;
                res.end_of_list = 1'b1;
                restart         = 1'b1;
              end
            end
          end
          PH_AFTER_ARG: begin
            if (tok.blank || tok.is_sep) begin
              if (tok.is_sep && !tok.blank) begin
                phase_nxt = PH_SKIP;
              end
              emit            = tok.fin;
              res.end_of_list = 1'b1;
              restart         = tok.fin;
            end else begin
              emit            = 1'b1;
              res.error_code  = nolp_pkg::ERR_NO_SEP;
              res.end_of_list = 1'b1;
              phase_nxt       = PH_DRAIN;
              restart         = tok.fin;
            end
          end
          default: ;
        endcase
      end
    end

    if (restart) begin
      phase_nxt = PH_SKIP;
      pos_nxt   = '0;
      nb_nxt    = '0;
      nf_nxt    = '0;
      af_nxt    = '0;
      al_nxt    = '0;
      seen_nxt  = 1'b0;
      depth_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_SKIP;
      pos_r       <= '0;
      nb_r        <= '0;
      nf_r        <= '0;
      af_r        <= '0;
      al_r        <= '0;
      seen_r      <= 1'b0;
      depth_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      nb_r    <= nb_nxt;
      nf_r    <= nf_nxt;
      af_r    <= af_nxt;
      al_r    <= al_nxt;
      seen_r  <= seen_nxt;
      depth_r <= depth_nxt;
      if (tok_pop && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tok_pop && emit) begin
      out_data_r <= res;
    end
  end

`ifndef SYNTHESIS
  a_err_ends_list: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.error_code != nolp_pkg::ERR_NONE |->
      out_data_r.end_of_list && !out_data_r.record_valid)
    else $error("error result without end of list");

  a_arg_needs_record: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.has_argument |-> out_data_r.record_valid)
    else $error("argument flagged without a record");

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_LIMIT)
    else $error("position ran past limit");
`endif

endmodule
